### rtl/core/dbof_pkg.sv
// ----------------------------------------------------------------------------
// dbof_pkg
// Shared constants of the 1-D DBSCAN outlier filter: widths, label codes,
// register indexes and reset values.
// ----------------------------------------------------------------------------
package dbof_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int DATA_W    = 32;
    localparam int THR_W     = 7;
    localparam int IDX_OUT_W = 6;
    localparam int CLUS_W    = 6;
    localparam int LBL_W     = 8;
    localparam int M_TDATA_W = 48;

    localparam logic [LBL_W-1:0] LBL_UNVISITED = 8'hFF;
    localparam logic [LBL_W-1:0] LBL_NOISE     = 8'hFE;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    localparam logic [DATA_W-1:0] RADIUS_RST = 32'h0001_0000;
    localparam logic [THR_W-1:0]  THRESH_RST = 7'd4;

endpackage

### rtl/core/dbof_near.sv
// ----------------------------------------------------------------------------
// dbof_near
// Neighbour test: |a - b| <= radius on signed Q16.16 values.
// ----------------------------------------------------------------------------
module dbof_near
    import dbof_pkg::*;
(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    input  logic        [DATA_W-1:0] radius,
    output logic                     near
);

    logic signed [DATA_W:0] diff;
    logic        [DATA_W:0] mag;

    always_comb begin
        diff = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        mag  = diff[DATA_W] ? (~diff + 1'b1) : diff;
        near = (mag <= {1'b0, radius});
    end

endmodule

### rtl/core/dbof_core.sv
// ----------------------------------------------------------------------------
// dbof_core
// Batch memories and clustering sequencer: load, label clear, outer visit,
// core count scan, neighbour claim scan, queue expansion and emission.
// ----------------------------------------------------------------------------
module dbof_core
    import dbof_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [DATA_W-1:0]    radius,
    input  logic [THR_W-1:0]     thresh,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_CLEAR, S_ORD, S_OCHK, S_CORE, S_CDEC, S_CLAIM,
        S_QCHK, S_QRD, S_QVAL, S_ERD, S_EOUT, S_EWAIT
    } state_t;

    // memories
    logic [DATA_W-1:0] samp_mem [MAX_POINTS];
    logic [LBL_W-1:0]  lbl_mem  [MAX_POINTS];
    logic [AW-1:0]     q_mem    [MAX_POINTS];

    logic              samp_we, lbl_we, q_we;
    logic [AW-1:0]     samp_wa, samp_ra, lbl_wa, lbl_ra, q_wa, q_ra;
    logic [DATA_W-1:0] samp_wd, samp_rd;
    logic [LBL_W-1:0]  lbl_wd, lbl_rd;
    logic [AW-1:0]     q_wd, q_rd;

    always_ff @(posedge aclk) begin
        if (samp_we) samp_mem[samp_wa] <= samp_wd;
        samp_rd <= samp_mem[samp_ra];
    end

    always_ff @(posedge aclk) begin
        if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
        lbl_rd <= lbl_mem[lbl_ra];
    end

    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_wa] <= q_wd;
        q_rd <= q_mem[q_ra];
    end

    // sequencer registers
    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [AW-1:0]       kd_reg, kd_next;
    logic                v_reg, v_next;
    logic [CW-1:0]       ncnt_reg, ncnt_next;
    logic [CW-1:0]       head_reg, head_next;
    logic [CW-1:0]       tail_reg, tail_next;
    logic [CLUS_W-1:0]   clus_reg, clus_next;
    logic                fromq_reg, fromq_next;
    logic [DATA_W-1:0]   pval_reg, pval_next;
    logic                ov_reg, ov_next;
    logic [M_TDATA_W-1:0] od_reg, od_next;
    logic                ol_reg, ol_next;

    logic near, scan_issue, scan_done, is_core, lbl_noise;
    logic [LBL_W-1:0] clus_lbl;

    dbof_near u_near (
        .a      (pval_reg),
        .b      (samp_rd),
        .radius (radius),
        .near   (near)
    );

    always_comb begin
        scan_issue = (k_reg < cnt_reg);
        scan_done  = !scan_issue && !v_reg;
        is_core    = (THR_W'(ncnt_reg) >= thresh);
        clus_lbl   = LBL_W'(clus_reg);
        lbl_noise  = (lbl_rd == LBL_NOISE) || (lbl_rd == LBL_UNVISITED);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        kd_next    = kd_reg;
        v_next     = v_reg;
        ncnt_next  = ncnt_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        clus_next  = clus_reg;
        fromq_next = fromq_reg;
        pval_next  = pval_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        ol_next    = ol_reg;

        samp_we = 1'b0;
        samp_wa = cnt_reg[AW-1:0];
        samp_wd = s_tdata;
        samp_ra = i_reg[AW-1:0];
        lbl_we  = 1'b0;
        lbl_wa  = i_reg[AW-1:0];
        lbl_wd  = LBL_UNVISITED;
        lbl_ra  = i_reg[AW-1:0];
        q_we    = 1'b0;
        q_wa    = tail_reg[AW-1:0];
        q_wd    = kd_reg;
        q_ra    = head_reg[AW-1:0];
        s_tready = (state_reg == S_LOAD);

        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    if (cnt_reg < CW'(MAX_POINTS)) begin
                        samp_we  = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        i_next     = '0;
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                if (i_reg < cnt_reg) begin
                    lbl_we = 1'b1;
                    i_next = i_reg + 1'b1;
                end else begin
                    i_next     = '0;
                    clus_next  = '0;
                    state_next = S_ORD;
                end
            end
            S_ORD: begin
                if (i_reg == cnt_reg) begin
                    i_next     = '0;
                    state_next = S_ERD;
                end else begin
                    state_next = S_OCHK;
                end
            end
            S_OCHK: begin
                if (lbl_rd != LBL_UNVISITED) begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_ORD;
                end else begin
                    pval_next  = samp_rd;
                    k_next     = '0;
                    v_next     = 1'b0;
                    ncnt_next  = '0;
                    fromq_next = 1'b0;
                    state_next = S_CORE;
                end
            end
            S_CORE: begin
                samp_ra = k_reg[AW-1:0];
                k_next  = scan_issue ? k_reg + 1'b1 : k_reg;
                v_next  = scan_issue;
                kd_next = k_reg[AW-1:0];
                if (v_reg && near) ncnt_next = ncnt_reg + 1'b1;
                if (scan_done) state_next = S_CDEC;
            end
            S_CDEC: begin
                k_next = '0;
                v_next = 1'b0;
                if (!fromq_reg) begin
                    lbl_we = 1'b1;
                    if (is_core) begin
                        lbl_wd     = clus_lbl;
                        head_next  = '0;
                        tail_next  = '0;
                        state_next = S_CLAIM;
                    end else begin
                        lbl_wd     = LBL_NOISE;
                        i_next     = i_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end else begin
                    state_next = is_core ? S_CLAIM : S_QCHK;
                end
            end
            S_CLAIM: begin
                samp_ra = k_reg[AW-1:0];
                lbl_ra  = k_reg[AW-1:0];
                lbl_wa  = kd_reg;
                lbl_wd  = clus_lbl;
                k_next  = scan_issue ? k_reg + 1'b1 : k_reg;
                v_next  = scan_issue;
                kd_next = k_reg[AW-1:0];
                if (v_reg && near) begin
                    if (lbl_rd == LBL_NOISE) begin
                        lbl_we = 1'b1;
                    end else if (lbl_rd == LBL_UNVISITED) begin
                        lbl_we    = 1'b1;
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                if (scan_done) state_next = S_QCHK;
            end
            S_QCHK: begin
                if (head_reg < tail_reg) begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_QRD;
                end else begin
                    clus_next  = clus_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_ORD;
                end
            end
            S_QRD: begin
                samp_ra    = q_rd;
                state_next = S_QVAL;
            end
            S_QVAL: begin
                pval_next  = samp_rd;
                k_next     = '0;
                v_next     = 1'b0;
                ncnt_next  = '0;
                fromq_next = 1'b1;
                state_next = S_CORE;
            end
            S_ERD: begin
                state_next = S_EOUT;
            end
            S_EOUT: begin
                // word: {pad, noise, cluster, value, index}
                od_next = {3'b000, lbl_noise,
                           lbl_noise ? {CLUS_W{1'b0}} : lbl_rd[CLUS_W-1:0],
                           samp_rd, IDX_OUT_W'(i_reg[AW-1:0])};
                ol_next    = (i_reg + 1'b1 == cnt_reg);
                ov_next    = 1'b1;
                state_next = S_EWAIT;
            end
            S_EWAIT: begin
                if (m_tready) begin
                    ov_next = 1'b0;
                    if (ol_reg) begin
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            v_reg     <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            clus_reg  <= '0;
            fromq_reg <= 1'b0;
            ov_reg    <= 1'b0;
            ol_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            v_reg     <= v_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            clus_reg  <= clus_next;
            fromq_reg <= fromq_next;
            ov_reg    <= ov_next;
            ol_reg    <= ol_next;
        end
        kd_reg   <= kd_next;
        ncnt_reg <= ncnt_next;
        pval_reg <= pval_next;
        od_reg   <= od_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;

endmodule

### rtl/core/dbscan_1d_outlier_filter_top.sv
// ----------------------------------------------------------------------------
// dbscan_1d_outlier_filter_top
// 1-D DBSCAN outlier filter: configuration registers and clustering core.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle until a word with tlast; samples beyond
// MAX_POINTS are dropped. The batch of N points is then labeled by a clear
// pass over the labels and a sequencer around sample and label memories with
// one read port each: each core test and each neighbour claim is a full scan
// of the sample memory. Results follow in index order, and no sample is
// accepted until the last result is taken.
module dbscan_1d_outlier_filter_top
    import dbof_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [31:0] sample_value
    input  logic                 s_tlast,   // batch_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [5:0] point_index, [37:6] point_value, [43:38] cluster_number,
    // [44] noise_flag, [47:45] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast    // final_result
);

    logic [DATA_W-1:0] radius_reg;
    logic [THR_W-1:0]  thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RST;
            thresh_reg <= THRESH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_wdata;
                CFG_THRESH: thresh_reg <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    dbof_core #(
        .MAX_POINTS (MAX_POINTS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .radius   (radius_reg),
        .thresh   (thresh_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/core/dbof_checker.sv
// ----------------------------------------------------------------------------
// dbof_checker
// Port-level checks of the outlier filter, bound to the top level.
// ----------------------------------------------------------------------------
module dbof_checker
    import dbof_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // loading and emission never overlap
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // batch end closes the input until results are out
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after batch end");

    // noise words carry cluster zero
    a_noise: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[44] |-> m_tdata[43:38] == 6'd0)
        else $error("noise word with nonzero cluster");

endmodule

bind dbscan_1d_outlier_filter_top dbof_checker u_dbof_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/dbscan_1d_outlier_filter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbscan_1d_outlier_filter_top_test
// Loads batches of Q16.16 samples under several radius/threshold settings,
// predicts the 1-D DBSCAN labeling of each batch and checks every result
// word in order, with random idle bursts on both stream sides in all but the final phase.
// ----------------------------------------------------------------------------
module dbscan_1d_outlier_filter_top_test;
    import dbof_pkg::*;

    localparam int NPTS      = 64;
    localparam int IDLE_LIM  = 60000;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [DATA_W-1:0]    value;
        logic [CLUS_W-1:0]    cluster;
        logic                 noise;
        logic                 last;
    } point_label_t;

    class label_scoreboard;
        logic [DATA_W-1:0] samples[NPTS];
        logic [LBL_W-1:0]  lbl[NPTS];
        int                loaded;
        logic [DATA_W-1:0] radius;
        logic [THR_W-1:0]  thresh;
        point_label_t      labels_due[$];
        int                fails;
        int                words_in;
        int                words_out;
        int                batches;

        function new();
            loaded = 0;
            radius = RADIUS_RST;
            thresh = THRESH_RST;
            fails = 0;
            words_in = 0;
            words_out = 0;
            batches = 0;
        endfunction

        function void set_reg(logic sel, logic [DATA_W-1:0] val);
            if (sel == CFG_RADIUS)
                radius = val;
            else
                thresh = val[THR_W-1:0];
        endfunction

        function bit near(int a, int b);
            longint sa, sb, d, ra;
            sa = $signed(samples[a]);
            sb = $signed(samples[b]);
            ra = {32'b0, radius};
            d = sa - sb;
            if (d < 0)
                d = -d;
            return d <= ra;
        endfunction

        function bit is_core(int p);
            int cnt;
            cnt = 0;
            for (int k = 0; k < loaded; k++)
                if (near(p, k))
                    cnt++;
            return cnt >= thresh;
        endfunction

        function void claim(int p, logic [LBL_W-1:0] c, ref int q[$]);
            for (int k = 0; k < loaded; k++) begin
                if (!near(p, k))
                    continue;
                if (lbl[k] == LBL_NOISE) begin
                    lbl[k] = c;
                end else if (lbl[k] == LBL_UNVISITED) begin
                    lbl[k] = c;
                    q.insert(q.size(), k);
                end
            end
        endfunction

        function void label_batch();
            int q[$];
            int nxt;
            int p;
            logic [LBL_W-1:0] c;
            point_label_t r;
            nxt = 0;
            for (int i = 0; i < NPTS; i++)
                lbl[i] = LBL_UNVISITED;
            for (int i = 0; i < loaded; i++) begin
                if (lbl[i] != LBL_UNVISITED)
                    continue;
                if (!is_core(i)) begin
                    lbl[i] = LBL_NOISE;
                    continue;
                end
                c = LBL_W'(nxt & 63);
                lbl[i] = c;
                q.delete();
                claim(i, c, q);
                while (q.size() != 0) begin
                    p = q.pop_front();
                    if (is_core(p))
                        claim(p, c, q);
                end
                nxt = (nxt + 1) & 127;
            end
            for (int i = 0; i < loaded; i++) begin
                r.idx = IDX_OUT_W'(i);
                r.value = samples[i];
                r.noise = (lbl[i] == LBL_NOISE) || (lbl[i] == LBL_UNVISITED);
                r.cluster = r.noise ? '0 : lbl[i][CLUS_W-1:0];
                r.last = (i == loaded - 1);
                labels_due.insert(labels_due.size(), r);
            end
            loaded = 0;
            batches++;
        endfunction

        function void note_sample(logic [DATA_W-1:0] v, logic end_of_batch);
            words_in++;
            if (loaded < NPTS) begin
                samples[loaded] = v;
                loaded++;
            end
            if (end_of_batch)
                label_batch();
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %0s: got %0h want %0h (t=%0t)", what, got, want, $time);
            fails++;
        endtask

        task check_word(logic [M_TDATA_W-1:0] d, logic last);
            point_label_t e;
            words_out++;
            if (labels_due.size() == 0) begin
                report("unexpected word", d, 0);
                return;
            end
            e = labels_due.pop_front();
            if (d[5:0] != e.idx)      report("point_index", d[5:0], e.idx);
            if (d[37:6] != e.value)   report("point_value", d[37:6], e.value);
            if (d[43:38] != e.cluster) report("cluster_number", d[43:38], e.cluster);
            if (d[44] != e.noise)     report("noise_flag", d[44], e.noise);
            if (last != e.last)       report("final_result", last, e.last);
        endtask

        function int pending();
            return labels_due.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic                 cfg_index;
    logic [DATA_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    label_scoreboard sb;
    bit              quiet;
    int              stall_left;
    int              idle_cycles;
    logic [DATA_W-1:0] centers[4];

    dbscan_1d_outlier_filter_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_sample(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tlast);
    end

    // receiver back-pressure in bursts
    always @(posedge aclk) begin
        if (quiet || !aresetn) begin
            m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIM);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task write_reg(logic sel, logic [DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        sb.set_reg(sel, (sel == CFG_RADIUS) ? val : {25'b0, val[THR_W-1:0]});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task send_word(logic [DATA_W-1:0] v, logic end_of_batch);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tlast <= end_of_batch;
        forever begin
            @(negedge aclk);
            if (s_tready)
                break;
        end
        @(posedge aclk);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        // let the monitor note the last accepted word first
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function logic [DATA_W-1:0] pick_sample();
        logic [DATA_W-1:0] step;
        step = sb.radius >> 1;
        if (step == 0)
            step = 1;
        if (step > 32'h0010_0000)
            step = 32'h0010_0000;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return centers[$urandom_range(0, 3)] + $urandom_range(0, 2 * step) - step;
    endfunction

    task send_batch(int n);
        for (int i = 0; i < 4; i++)
            centers[i] = $urandom;
        for (int i = 0; i < n; i++)
            send_word(pick_sample(), i == n - 1);
    endtask

    task random_phase(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
            send_batch(n);
            sent += n;
        end
        drain();
    endtask

    initial begin
        sb = new();
        quiet = 1'b0;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_RADIUS;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, extremes, single point
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0001_0000, 1'b1);
        for (int i = 0; i < 5; i++)
            send_word(32'h0002_0000 + i * 32'h0000_8000, i == 4);
        drain();
        // widest radius, threshold above small batch
        write_reg(CFG_RADIUS, 32'hFFFF_FFFF);
        write_reg(CFG_THRESH, 32'd64);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        drain();
        // zero radius, threshold zero via masked write
        write_reg(CFG_RADIUS, 32'h0);
        write_reg(CFG_THRESH, 32'hFFFF_FF80);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h1234_5679, 1'b1);
        drain();
        // overflow: last flag rides on a dropped sample
        write_reg(CFG_RADIUS, 32'hFFFF_FFFF);
        write_reg(CFG_THRESH, 32'd64);
        for (int i = 0; i < 66; i++)
            send_word($urandom, i == 65);
        drain();

        write_reg(CFG_RADIUS, 32'h0001_0000);
        write_reg(CFG_THRESH, 32'd1);
        random_phase(60);
        write_reg(CFG_RADIUS, 32'h0004_0000);
        write_reg(CFG_THRESH, 32'd3);
        random_phase(70);
        write_reg(CFG_RADIUS, $urandom);
        write_reg(CFG_THRESH, 32'd2);
        random_phase(60);
        write_reg(CFG_RADIUS, 32'h0000_0100);
        write_reg(CFG_THRESH, 32'd127);
        random_phase(40);
        write_reg(CFG_RADIUS, 32'h0010_0000);
        write_reg(CFG_THRESH, $urandom_range(1, 6));
        random_phase(80);
        write_reg(CFG_RADIUS, 32'h0000_8000);
        write_reg(CFG_THRESH, 32'd4);
        random_phase(70);
        quiet = 1'b1;
        write_reg(CFG_RADIUS, 32'h0002_0000);
        write_reg(CFG_THRESH, 32'd3);
        random_phase(50);

        repeat (200) @(posedge aclk);
        $display("covered %0d batches, %0d sample words in, %0d label words out",
                 sb.batches, sb.words_in, sb.words_out);
        $display("radius from 0 to max, threshold 0..127, overflow and extreme samples");
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            if (sb.pending() != 0)
                $display("%0d expected words never arrived", sb.pending());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/dbof_pkg.sv
rtl/core/dbof_near.sv
rtl/core/dbof_core.sv
rtl/core/dbscan_1d_outlier_filter_top.sv
rtl/core/dbof_checker.sv
tb/dbscan_1d_outlier_filter_top_test.sv
